// ===== hdl/magnetometer_sphere_coverage_binner_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sphere coverage binner checks
// Concurrent property wrappers clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MAGNETOMETER_SPHERE_COVERAGE_BINNER_ASSERT_SVH
`define MAGNETOMETER_SPHERE_COVERAGE_BINNER_ASSERT_SVH

// same-cycle implication
`define MSCB_ASSERT_IMP(name, ante, cons) \
name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mscb check failed");

// next-cycle implication
`define MSCB_ASSERT_NXT(name, ante, cons) \
name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mscb check failed");

`endif

// ===== hdl/mscb_pkg.sv =====
// ----------------------------------------------------------------------------
// mscb_pkg
// Shared widths, constants, word types and angle helpers of the binner.
// ----------------------------------------------------------------------------
package mscb_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int COUNT_BITS    = 16;
    localparam int SUM_BITS      = 32;
    localparam int ANGLE_BITS    = 16;

    localparam int REGION_BITS   = 7;
    localparam int REGIONS       = 100;
    localparam int FEED_BITS     = 24;
    localparam int BIAS_BITS     = 10;
    localparam int COVER_BITS    = 7;
    localparam logic [BIAS_BITS-1:0] BIAS_RESET = 10'd100;

    // derived datapath widths
    localparam int PRE_SHIFT     = 30 - SAMPLE_BITS;
    localparam int D_BITS        = SAMPLE_BITS + 1;
    localparam int SQ_BITS       = 2 * SAMPLE_BITS;
    localparam int Q_BITS        = SQ_BITS + 1;
    localparam int ROOT_STEPS    = (Q_BITS + 2 * PRE_SHIFT + 1) / 2;
    localparam int ROOT_BITS     = ROOT_STEPS;
    localparam int RAD_BITS      = 2 * ROOT_STEPS;
    localparam int REM_BITS      = ROOT_BITS + 3;
    localparam int ROOT_CNT_BITS = $clog2(ROOT_STEPS);
    localparam int CORDIC_BITS   = D_BITS + PRE_SHIFT + 5;
    localparam int STEP_BITS     = $clog2(ANGLE_BITS);

    // action codes
    localparam logic ACT_FEED = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // first region of each band
    localparam logic [REGION_BITS-1:0] REG_ARCTIC    = 7'd0;
    localparam logic [REGION_BITS-1:0] REG_NTEMP     = 7'd1;
    localparam logic [REGION_BITS-1:0] REG_NTROP     = 7'd16;
    localparam logic [REGION_BITS-1:0] REG_STROP     = 7'd50;
    localparam logic [REGION_BITS-1:0] REG_STEMP     = 7'd84;
    localparam logic [REGION_BITS-1:0] REG_ANTARCTIC = 7'd99;

    // angles, full turn = 2^32
    localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
    localparam logic [31:0] ROUND_HALF = 32'd1 << (31 - ANGLE_BITS);
    localparam logic [31:0] CAP_TURN   = 32'd936798868;
    localparam logic [31:0] BAND_TURN  = 32'd511142770;

    // round a 32-bit turn value to the working angle width, modulo one turn
    function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [31:0] turn);
        logic [31:0] t;
        t = turn + ROUND_HALF;
        return t[31 -: ANGLE_BITS];
    endfunction

    localparam logic signed [ANGLE_BITS-1:0] CAP_ANGLE  = $signed(to_angle(CAP_TURN));
    localparam logic signed [ANGLE_BITS-1:0] BAND_ANGLE = $signed(to_angle(BAND_TURN));

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [31:0] atan_step(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] sample_x;
        logic signed [SAMPLE_BITS-1:0] sample_y;
        logic signed [SAMPLE_BITS-1:0] sample_z;
        logic [REGION_BITS-1:0]        region_pick;
    } in_word_t;

    typedef struct packed {
        logic [REGION_BITS-1:0]     region;
        logic                       binned;
        logic [COUNT_BITS-1:0]      region_samples;
        logic signed [SUM_BITS-1:0] sum_x;
        logic signed [SUM_BITS-1:0] sum_y;
        logic signed [SUM_BITS-1:0] sum_z;
        logic [COVER_BITS-1:0]      coverage;
        logic [FEED_BITS-1:0]       readings_taken;
        logic                       bias_ready;
    } out_word_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] hits;
        logic [SUM_BITS-1:0]   sx;
        logic [SUM_BITS-1:0]   sy;
        logic [SUM_BITS-1:0]   sz;
    } entry_t;

    typedef struct packed {
        logic                   rd;
        logic                   wr;
        logic [REGION_BITS-1:0] addr;
    } mem_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SQR,
        ST_ROOT,
        ST_WAIT_LON,
        ST_WAIT_LAT,
        ST_CLASS,
        ST_MRD,
        ST_MUPD,
        ST_RDATA,
        ST_OUT
    } state_t;

endpackage

// ===== hdl/mscb_sqrt.sv =====
// ----------------------------------------------------------------------------
// mscb_sqrt
// Restoring integer square root of (q << 2*PRE_SHIFT), one root bit a cycle.
// ----------------------------------------------------------------------------
module mscb_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mscb_pkg::Q_BITS-1:0]    operand,
    output logic                           busy,
    output logic [mscb_pkg::ROOT_BITS-1:0] root
);

    logic [mscb_pkg::RAD_BITS-1:0]      rad_reg;
    logic [mscb_pkg::REM_BITS-1:0]      rem_reg;
    logic [mscb_pkg::ROOT_BITS-1:0]     root_reg;
    logic [mscb_pkg::ROOT_CNT_BITS-1:0] cnt_reg;
    logic                               busy_reg;

    logic [mscb_pkg::REM_BITS-1:0] rem_sh;
    logic [mscb_pkg::REM_BITS-1:0] trial;
    logic                          fits;

    // trial subtract for the next root bit
    always_comb
    begin
        rem_sh = {rem_reg[mscb_pkg::REM_BITS-3:0], rad_reg[mscb_pkg::RAD_BITS-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        fits   = (rem_sh >= trial);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == mscb_pkg::ROOT_CNT_BITS'(mscb_pkg::ROOT_STEPS - 1))
                busy_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= mscb_pkg::RAD_BITS'(operand) << (2 * mscb_pkg::PRE_SHIFT);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[mscb_pkg::ROOT_BITS-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ===== hdl/mscb_cordic.sv =====
// ----------------------------------------------------------------------------
// mscb_cordic
// Vectoring CORDIC, one micro-rotation a cycle; angle in 2^32-per-turn units.
// ----------------------------------------------------------------------------
module mscb_cordic (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [mscb_pkg::CORDIC_BITS-1:0] a_in,
    input  logic signed [mscb_pkg::CORDIC_BITS-1:0] b_in,
    output logic                                    busy,
    output logic [31:0]                             angle
);

    logic signed [mscb_pkg::CORDIC_BITS-1:0] a_reg;
    logic signed [mscb_pkg::CORDIC_BITS-1:0] b_reg;
    logic [31:0]                             acc_reg;
    logic [mscb_pkg::STEP_BITS-1:0]          step_reg;
    logic                                    busy_reg;

    logic signed [mscb_pkg::CORDIC_BITS-1:0] sa;
    logic signed [mscb_pkg::CORDIC_BITS-1:0] sb;
    logic [31:0]                             rot;
    logic                                    in_zero;

    always_comb
    begin
        sa      = a_reg >>> step_reg;
        sb      = b_reg >>> step_reg;
        rot     = mscb_pkg::atan_step(5'(step_reg));
        in_zero = (a_in == '0) && (b_in == '0);
    end

    // control: a zero vector gives angle zero with no iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= !in_zero;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == mscb_pkg::STEP_BITS'(mscb_pkg::ANGLE_BITS - 1))
                busy_reg <= 1'b0;
        end
    end

    // rotation datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (in_zero)
            begin
                acc_reg <= '0;
                a_reg   <= a_in;
                b_reg   <= b_in;
            end
            else if (a_in < 0)
            begin
                acc_reg <= mscb_pkg::HALF_TURN;
                a_reg   <= -a_in;
                b_reg   <= -b_in;
            end
            else
            begin
                acc_reg <= '0;
                a_reg   <= a_in;
                b_reg   <= b_in;
            end
        end
        else if (busy_reg)
        begin
            if (b_reg > 0)
            begin
                a_reg   <= a_reg + sb;
                b_reg   <= b_reg - sa;
                acc_reg <= acc_reg + rot;
            end
            else
            begin
                a_reg   <= a_reg - sb;
                b_reg   <= b_reg + sa;
                acc_reg <= acc_reg - rot;
            end
        end
    end

    assign busy  = busy_reg;
    assign angle = acc_reg;

endmodule

// ===== hdl/mscb_mem.sv =====
// ----------------------------------------------------------------------------
// mscb_mem
// Region store: count and three sums per region, a registered read,
// per-entry valid flags so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module mscb_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  mscb_pkg::mem_cmd_t cmd,
    input  mscb_pkg::entry_t   wr_data,
    output mscb_pkg::entry_t   rd_data
);

    mscb_pkg::entry_t             mem [mscb_pkg::REGIONS];
    logic [mscb_pkg::REGIONS-1:0] valid_reg;
    mscb_pkg::entry_t             q_reg;
    logic                         q_valid_reg;

    // storage array
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
            mem[cmd.addr] <= wr_data;
        if (cmd.rd)
            q_reg <= mem[cmd.addr];
    end

    // valid flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr)
                valid_reg[cmd.addr] <= 1'b1;
            if (cmd.rd)
                q_valid_reg <= valid_reg[cmd.addr];
        end
    end

    assign rd_data = q_valid_reg ? q_reg : '0;

endmodule

// ===== hdl/magnetometer_sphere_coverage_binner.sv =====
// ----------------------------------------------------------------------------
// magnetometer_sphere_coverage_binner
// Hard-iron bias estimate and equal-area sphere coverage binning of readings.
// ----------------------------------------------------------------------------
// Use:
//   Input words (in_valid / in_stall) carry either a feed of one reading or a
//   read of one region. Each input word gives exactly one output word
//   (out_valid / out_stall). bias_we writes bias_samples from bias_data; the
//   user must write only while the block is idle; the block does not enforce
//   it. One word is worked on at a time; in_stall is high from the cycle
//   after acceptance until the result moves into the output register. A
//   tracking feed and an out-of-range read go straight to the output, a
//   region read first reads the store, a feed whose offset-free vector is
//   zero goes straight to the read-modify-write of the region store, and any
//   other binned feed runs the 16-step longitude CORDIC, the 31-step square
//   root started in the cycle after it, the 16-step latitude pass on the
//   same CORDIC, the classify state and that read-modify-write. The next word
//   can be accepted in the cycle after the result loads. A finished result
//   waits in the output register; a new word is accepted meanwhile, and only
//   the hand-over of its own result waits on out_stall. Reset clears the
//   region store through per-entry valid flags at once, sets bias_samples to
//   100, extremes to their limits, offsets to zero.
// ----------------------------------------------------------------------------
module magnetometer_sphere_coverage_binner (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               bias_we,
    input  logic [mscb_pkg::BIAS_BITS-1:0]     bias_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  mscb_pkg::in_word_t                 in_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output mscb_pkg::out_word_t                out_word
);

    localparam int SB = mscb_pkg::SAMPLE_BITS;
    localparam int DB = mscb_pkg::D_BITS;
    localparam int CB = mscb_pkg::CORDIC_BITS;
    localparam int AB = mscb_pkg::ANGLE_BITS;

    mscb_pkg::state_t state_reg, state_next;

    mscb_pkg::in_word_t                item_reg;
    logic [mscb_pkg::BIAS_BITS-1:0]    bias_reg;
    logic signed [SB-1:0]              low_x_reg, low_y_reg, low_z_reg;
    logic signed [SB-1:0]              high_x_reg, high_y_reg, high_z_reg;
    logic signed [SB-1:0]              off_x_reg, off_y_reg, off_z_reg;
    logic [mscb_pkg::FEED_BITS-1:0]    feeds_reg;
    logic [mscb_pkg::COVER_BITS-1:0]   covered_reg;
    logic signed [DB-1:0]              dx_reg, dy_reg, dz_reg;
    logic [mscb_pkg::SQ_BITS-1:0]      sqx_reg, sqy_reg;
    logic [AB-1:0]                     lon_reg;
    logic [mscb_pkg::REGION_BITS-1:0]  region_reg;
    mscb_pkg::out_word_t               res_reg;
    mscb_pkg::out_word_t               out_word_reg;
    mscb_pkg::out_word_t               out_word_next;
    logic                              out_valid_reg;

    // handshake and unit control
    logic                              accept;
    logic                              out_load;
    logic                              sqrt_start;
    logic                              cordic_start;
    logic                              cordic_lat;
    mscb_pkg::mem_cmd_t                mem_cmd;

    // unit signals
    logic                              sqrt_busy;
    logic [mscb_pkg::ROOT_BITS-1:0]    root;
    logic                              cordic_busy;
    logic [31:0]                       angle;
    logic signed [CB-1:0]              cordic_a, cordic_b;
    mscb_pkg::entry_t                  rd_data;
    mscb_pkg::entry_t                  wr_data;

    // datapath helpers
    logic [mscb_pkg::FEED_BITS-1:0]    bias_ext;
    logic                              tracking;
    logic                              forming;
    logic signed [SB:0]                pair_x, pair_y, pair_z;
    logic signed [SB-1:0]              use_x, use_y, use_z;
    logic signed [DB-1:0]              dx_next, dy_next, dz_next;
    logic signed [2*DB-1:0]            prod_x, prod_y;
    logic                              d_zero;
    logic                              pick_ok;
    logic [AB-1:0]                     lon_ang;
    logic signed [AB-1:0]              lat;
    logic [AB+3:0]                     p15;
    logic [AB+5:0]                     p34;
    logic [3:0]                        s15;
    logic [5:0]                        s34;
    logic [mscb_pkg::REGION_BITS-1:0]  class_region;
    logic                              sat;

    // ------------------------------------------------------------------
    // bias, offsets and deltas
    always_comb
    begin
        bias_ext = mscb_pkg::FEED_BITS'(bias_reg);
        tracking = (feeds_reg < bias_ext);
        forming  = (feeds_reg == bias_ext);
        pair_x   = {low_x_reg[SB-1], low_x_reg} + {high_x_reg[SB-1], high_x_reg};
        pair_y   = {low_y_reg[SB-1], low_y_reg} + {high_y_reg[SB-1], high_y_reg};
        pair_z   = {low_z_reg[SB-1], low_z_reg} + {high_z_reg[SB-1], high_z_reg};
        use_x    = forming ? pair_x[SB:1] : off_x_reg;
        use_y    = forming ? pair_y[SB:1] : off_y_reg;
        use_z    = forming ? pair_z[SB:1] : off_z_reg;
        dx_next  = {item_reg.sample_x[SB-1], item_reg.sample_x} - {use_x[SB-1], use_x};
        dy_next  = {item_reg.sample_y[SB-1], item_reg.sample_y} - {use_y[SB-1], use_y};
        dz_next  = {item_reg.sample_z[SB-1], item_reg.sample_z} - {use_z[SB-1], use_z};
        prod_x   = dx_reg * dx_reg;
        prod_y   = dy_reg * dy_reg;
        d_zero   = (dx_reg == '0) && (dy_reg == '0) && (dz_reg == '0);
        pick_ok  = (item_reg.region_pick < mscb_pkg::REGION_BITS'(mscb_pkg::REGIONS));
    end

    // CORDIC operands: longitude pass, then latitude pass
    always_comb
    begin
        if (cordic_lat)
        begin
            cordic_a = {{(CB - mscb_pkg::ROOT_BITS){1'b0}}, root};
            cordic_b = {{(CB - DB - mscb_pkg::PRE_SHIFT){dz_reg[DB-1]}}, dz_reg,
                        {mscb_pkg::PRE_SHIFT{1'b0}}};
        end
        else
        begin
            cordic_a = {{(CB - DB - mscb_pkg::PRE_SHIFT){dx_reg[DB-1]}}, dx_reg,
                        {mscb_pkg::PRE_SHIFT{1'b0}}};
            cordic_b = {{(CB - DB - mscb_pkg::PRE_SHIFT){dy_reg[DB-1]}}, dy_reg,
                        {mscb_pkg::PRE_SHIFT{1'b0}}};
        end
    end

    // region from latitude and longitude
    always_comb
    begin
        lon_ang = mscb_pkg::to_angle(angle + mscb_pkg::HALF_TURN);
        lat     = $signed(mscb_pkg::to_angle(angle));
        p15     = {lon_reg, 4'b0} - {4'b0, lon_reg};
        p34     = {1'b0, lon_reg, 5'b0} + {5'b0, lon_reg, 1'b0};
        s15     = p15[AB+3 -: 4];
        s34     = p34[AB+5 -: 6];
        if (lat > mscb_pkg::CAP_ANGLE)
            class_region = mscb_pkg::REG_ARCTIC;
        else if (lat < -mscb_pkg::CAP_ANGLE)
            class_region = mscb_pkg::REG_ANTARCTIC;
        else if ((lat > mscb_pkg::BAND_ANGLE) || (lat < -mscb_pkg::BAND_ANGLE))
            class_region = (lat > 0) ? mscb_pkg::REG_NTEMP + mscb_pkg::REGION_BITS'(s15)
                                     : mscb_pkg::REG_STEMP + mscb_pkg::REGION_BITS'(s15);
        else
            class_region = (lat >= 0) ? mscb_pkg::REG_NTROP + mscb_pkg::REGION_BITS'(s34)
                                      : mscb_pkg::REG_STROP + mscb_pkg::REGION_BITS'(s34);
    end

    // store update: count and raw sums, held once the count saturates
    always_comb
    begin
        sat        = &rd_data.hits;
        wr_data.hits = rd_data.hits + 1'b1;
        wr_data.sx = rd_data.sx + {{(mscb_pkg::SUM_BITS - SB){item_reg.sample_x[SB-1]}},
                                   item_reg.sample_x};
        wr_data.sy = rd_data.sy + {{(mscb_pkg::SUM_BITS - SB){item_reg.sample_y[SB-1]}},
                                   item_reg.sample_y};
        wr_data.sz = rd_data.sz + {{(mscb_pkg::SUM_BITS - SB){item_reg.sample_z[SB-1]}},
                                   item_reg.sample_z};
    end

    // output word as loaded: result fields plus running counters
    always_comb
    begin
        out_word_next                = res_reg;
        out_word_next.coverage       = covered_reg;
        out_word_next.readings_taken = feeds_reg;
        out_word_next.bias_ready     = (feeds_reg > bias_ext);
    end

    // ------------------------------------------------------------------
    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mscb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // sequencer next state and strobes
    always_comb
    begin
        state_next   = state_reg;
        accept       = 1'b0;
        out_load     = 1'b0;
        sqrt_start   = 1'b0;
        cordic_start = 1'b0;
        cordic_lat   = 1'b0;
        mem_cmd      = '0;
        case (state_reg)
            mscb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    accept     = 1'b1;
                    state_next = mscb_pkg::ST_PREP;
                end
            end
            mscb_pkg::ST_PREP:
            begin
                if (item_reg.action == mscb_pkg::ACT_READ)
                begin
                    if (pick_ok)
                    begin
                        mem_cmd.rd   = 1'b1;
                        mem_cmd.addr = item_reg.region_pick;
                        state_next   = mscb_pkg::ST_RDATA;
                    end
                    else
                        state_next = mscb_pkg::ST_OUT;
                end
                else if (tracking)
                    state_next = mscb_pkg::ST_OUT;
                else
                    state_next = mscb_pkg::ST_SQR;
            end
            mscb_pkg::ST_SQR:
            begin
                if (d_zero)
                    state_next = mscb_pkg::ST_MRD;
                else
                begin
                    cordic_start = 1'b1;
                    state_next   = mscb_pkg::ST_ROOT;
                end
            end
            mscb_pkg::ST_ROOT:
            begin
                sqrt_start = 1'b1;
                state_next = mscb_pkg::ST_WAIT_LON;
            end
            mscb_pkg::ST_WAIT_LON:
            begin
                cordic_lat = 1'b1;
                if (!sqrt_busy && !cordic_busy)
                begin
                    cordic_start = 1'b1;
                    state_next   = mscb_pkg::ST_WAIT_LAT;
                end
            end
            mscb_pkg::ST_WAIT_LAT:
            begin
                if (!cordic_busy)
                    state_next = mscb_pkg::ST_CLASS;
            end
            mscb_pkg::ST_CLASS:
                state_next = mscb_pkg::ST_MRD;
            mscb_pkg::ST_MRD:
            begin
                mem_cmd.rd   = 1'b1;
                mem_cmd.addr = region_reg;
                state_next   = mscb_pkg::ST_MUPD;
            end
            mscb_pkg::ST_MUPD:
            begin
                mem_cmd.wr   = !sat;
                mem_cmd.addr = region_reg;
                state_next   = mscb_pkg::ST_OUT;
            end
            mscb_pkg::ST_RDATA:
                state_next = mscb_pkg::ST_OUT;
            mscb_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = mscb_pkg::ST_IDLE;
                end
            end
            default:
                state_next = mscb_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // architectural state: bias count, extremes, offsets, counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg    <= mscb_pkg::BIAS_RESET;
            low_x_reg   <= {1'b0, {(SB-1){1'b1}}};
            low_y_reg   <= {1'b0, {(SB-1){1'b1}}};
            low_z_reg   <= {1'b0, {(SB-1){1'b1}}};
            high_x_reg  <= {1'b1, {(SB-1){1'b0}}};
            high_y_reg  <= {1'b1, {(SB-1){1'b0}}};
            high_z_reg  <= {1'b1, {(SB-1){1'b0}}};
            off_x_reg   <= '0;
            off_y_reg   <= '0;
            off_z_reg   <= '0;
            feeds_reg   <= '0;
            covered_reg <= '0;
        end
        else
        begin
            if (bias_we)
                bias_reg <= bias_data;
            if ((state_reg == mscb_pkg::ST_PREP) && (item_reg.action == mscb_pkg::ACT_FEED))
            begin
                if (tracking)
                begin
                    if (item_reg.sample_x < low_x_reg)  low_x_reg  <= item_reg.sample_x;
                    if (item_reg.sample_x > high_x_reg) high_x_reg <= item_reg.sample_x;
                    if (item_reg.sample_y < low_y_reg)  low_y_reg  <= item_reg.sample_y;
                    if (item_reg.sample_y > high_y_reg) high_y_reg <= item_reg.sample_y;
                    if (item_reg.sample_z < low_z_reg)  low_z_reg  <= item_reg.sample_z;
                    if (item_reg.sample_z > high_z_reg) high_z_reg <= item_reg.sample_z;
                    feeds_reg <= feeds_reg + 1'b1;
                end
                else
                begin
                    off_x_reg <= use_x;
                    off_y_reg <= use_y;
                    off_z_reg <= use_z;
                    if (feeds_reg != '1)
                        feeds_reg <= feeds_reg + 1'b1;
                end
            end
            if ((state_reg == mscb_pkg::ST_MUPD) && !sat && (rd_data.hits == '0))
                covered_reg <= covered_reg + 1'b1;
        end
    end

    // working registers of the current word
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_word;
        case (state_reg)
            mscb_pkg::ST_PREP:
            begin
                dx_reg  <= dx_next;
                dy_reg  <= dy_next;
                dz_reg  <= dz_next;
                res_reg <= '0;
            end
            mscb_pkg::ST_SQR:
            begin
                sqx_reg    <= prod_x[mscb_pkg::SQ_BITS-1:0];
                sqy_reg    <= prod_y[mscb_pkg::SQ_BITS-1:0];
                region_reg <= mscb_pkg::REG_ARCTIC;
            end
            mscb_pkg::ST_WAIT_LON:
                lon_reg <= lon_ang;
            mscb_pkg::ST_CLASS:
                region_reg <= class_region;
            mscb_pkg::ST_MUPD:
            begin
                res_reg.region         <= region_reg;
                res_reg.binned         <= !sat;
                res_reg.region_samples <= sat ? rd_data.hits : wr_data.hits;
                res_reg.sum_x          <= sat ? rd_data.sx : wr_data.sx;
                res_reg.sum_y          <= sat ? rd_data.sy : wr_data.sy;
                res_reg.sum_z          <= sat ? rd_data.sz : wr_data.sz;
            end
            mscb_pkg::ST_RDATA:
            begin
                res_reg.region         <= item_reg.region_pick;
                res_reg.binned         <= 1'b0;
                res_reg.region_samples <= rd_data.hits;
                res_reg.sum_x          <= rd_data.sx;
                res_reg.sum_y          <= rd_data.sy;
                res_reg.sum_z          <= rd_data.sz;
            end
            default:
            begin
            end
        endcase
        if (out_load)
            out_word_reg <= out_word_next;
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign in_stall  = (state_reg != mscb_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // ------------------------------------------------------------------
    // units
    mscb_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand ({1'b0, sqx_reg} + {1'b0, sqy_reg}),
        .busy    (sqrt_busy),
        .root    (root)
    );

    mscb_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .a_in  (cordic_a),
        .b_in  (cordic_b),
        .busy  (cordic_busy),
        .angle (angle)
    );

    mscb_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mem_cmd),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

endmodule

// ===== hdl/mscb_checker.sv =====
// ----------------------------------------------------------------------------
// mscb_checker
// Port-level checks on the binner, bound to the top level.
// ----------------------------------------------------------------------------
`include "magnetometer_sphere_coverage_binner_assert.svh"

module mscb_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input mscb_pkg::out_word_t out_word
);

    logic binned_ok;
    logic range_ok;

    // a binned word follows the bias estimate and counts at least one sample
    assign binned_ok = out_word.bias_ready && (out_word.region_samples != '0);

    // region index and coverage stay within the sphere's regions
    assign range_ok =
        (out_word.region <= mscb_pkg::REGION_BITS'(mscb_pkg::REGIONS - 1)) &&
        (out_word.coverage <= mscb_pkg::COVER_BITS'(mscb_pkg::REGIONS));

    // a stalled result word holds
    `MSCB_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

    // one word at a time: busy straight after acceptance
    `MSCB_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    `MSCB_ASSERT_IMP(a_binned_sane, out_valid && out_word.binned, binned_ok)

    `MSCB_ASSERT_IMP(a_ranges, out_valid, range_ok)

endmodule

bind magnetometer_sphere_coverage_binner mscb_checker u_mscb_checker (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Sphere coverage binner testbench
// Drives feed and read words under random idling and a long output hold-off,
// predicts every result word in a scoreboard and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 400;

    logic      clk;
    logic      rst_n;
    logic      bias_we;
    logic [mscb_pkg::BIAS_BITS-1:0] bias_data;
    logic      in_valid;
    logic      in_stall;
    mscb_pkg::in_word_t  in_word;
    logic      out_valid;
    logic      out_stall;
    mscb_pkg::out_word_t out_word;

    int  errors;
    int  cycles;
    int  feeds_sent;
    int  reads_sent;
    int  binned_seen;
    bit  hold_req;
    bit  quiet;

    magnetometer_sphere_coverage_binner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bias_we   (bias_we),
        .bias_data (bias_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // print one mismatch line and count it
    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the binner state and the expected words
    // ------------------------------------------------------------------
    class binner_scoreboard;
        logic [mscb_pkg::BIAS_BITS-1:0] bias_count;
        longint lo[3];
        longint hi[3];
        longint offs[3];
        int unsigned feeds_seen;
        logic [mscb_pkg::COUNT_BITS-1:0] hits[mscb_pkg::REGIONS];
        logic [mscb_pkg::SUM_BITS-1:0] sums[mscb_pkg::REGIONS][3];
        int unsigned covered_regions;
        mscb_pkg::out_word_t pending[$];

        function void clear();
            bias_count = mscb_pkg::BIAS_RESET;
            for (int a = 0; a < 3; a++)
            begin
                lo[a] = 32767;
                hi[a] = -32768;
                offs[a] = 0;
            end
            feeds_seen = 0;
            covered_regions = 0;
            for (int r = 0; r < mscb_pkg::REGIONS; r++)
            begin
                hits[r] = '0;
                for (int a = 0; a < 3; a++)
                    sums[r][a] = '0;
            end
            pending.delete();
        endfunction

        // vectoring CORDIC, angle in 2^32 per turn
        function logic [31:0] arc(input longint a, input longint b);
            logic [31:0] acc;
            longint na;
            longint nb;
            acc = 32'd0;
            if (a == 0 && b == 0)
                return 32'd0;
            if (a < 0)
            begin
                a = -a;
                b = -b;
                acc = mscb_pkg::HALF_TURN;
            end
            for (int i = 0; i < mscb_pkg::ANGLE_BITS; i++)
            begin
                if (b > 0)
                begin
                    na = a + (b >>> i);
                    nb = b - (a >>> i);
                    acc = acc + atan_table(i);
                end
                else
                begin
                    na = a - (b >>> i);
                    nb = b + (a >>> i);
                    acc = acc - atan_table(i);
                end
                a = na;
                b = nb;
            end
            return acc;
        endfunction

        function logic [31:0] atan_table(input int i);
            logic [31:0] t[16] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                                   32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                                   32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                                   32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
            return t[i];
        endfunction

        function logic [mscb_pkg::ANGLE_BITS-1:0] round_angle(input logic [31:0] t);
            logic [31:0] s;
            s = t + (32'd1 << (31 - mscb_pkg::ANGLE_BITS));
            return s[31 -: mscb_pkg::ANGLE_BITS];
        endfunction

        function longint unsigned int_root(input longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function int region_of(input longint dx, input longint dy, input longint dz);
            longint scale;
            longint unsigned q;
            longint unsigned rad;
            longint unsigned lon;
            longint lat;
            longint cap;
            longint band;
            longint unsigned s;
            logic [mscb_pkg::ANGLE_BITS-1:0] lat_u;
            scale = longint'(1) << mscb_pkg::PRE_SHIFT;
            if (dx == 0 && dy == 0 && dz == 0)
                return 0;
            q = longint'(dx * dx) + longint'(dy * dy);
            rad = int_root(q << (2 * mscb_pkg::PRE_SHIFT));
            lon = round_angle(arc(dx * scale, dy * scale) + mscb_pkg::HALF_TURN);
            lat_u = round_angle(arc(longint'(rad), dz * scale));
            lat = longint'($signed(lat_u));
            cap = round_angle(mscb_pkg::CAP_TURN);
            band = round_angle(mscb_pkg::BAND_TURN);
            if (lat > cap)
                return 0;
            if (lat < -cap)
                return 99;
            if (lat > band || lat < -band)
            begin
                s = (lon * 15) >> mscb_pkg::ANGLE_BITS;
                if (s > 14)
                    s = 14;
                return lat > 0 ? 1 + int'(s) : 84 + int'(s);
            end
            s = (lon * 34) >> mscb_pkg::ANGLE_BITS;
            if (s > 33)
                s = 33;
            return lat >= 0 ? 16 + int'(s) : 50 + int'(s);
        endfunction

        function void fill_entry(ref mscb_pkg::out_word_t w, input int r);
            w.region = r[mscb_pkg::REGION_BITS-1:0];
            w.region_samples = hits[r];
            w.sum_x = sums[r][0];
            w.sum_y = sums[r][1];
            w.sum_z = sums[r][2];
        endfunction

        // predict the result of one accepted input word
        function void note_input(input mscb_pkg::in_word_t w);
            mscb_pkg::out_word_t o;
            longint smp[3];
            int r;
            o = '0;
            smp[0] = w.sample_x;
            smp[1] = w.sample_y;
            smp[2] = w.sample_z;
            if (w.action == mscb_pkg::ACT_READ)
            begin
                if (w.region_pick < mscb_pkg::REGIONS)
                    fill_entry(o, w.region_pick);
            end
            else if (feeds_seen < bias_count)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    if (smp[a] < lo[a]) lo[a] = smp[a];
                    if (smp[a] > hi[a]) hi[a] = smp[a];
                end
                feeds_seen++;
            end
            else
            begin
                if (feeds_seen == bias_count)
                    for (int a = 0; a < 3; a++)
                        offs[a] = (lo[a] + hi[a]) >>> 1;
                if (feeds_seen < 24'hFFFFFF)
                    feeds_seen++;
                r = region_of(smp[0] - offs[0], smp[1] - offs[1], smp[2] - offs[2]);
                if (hits[r] != '1)
                begin
                    if (hits[r] == 0)
                        covered_regions++;
                    hits[r]++;
                    for (int a = 0; a < 3; a++)
                        sums[r][a] = sums[r][a] + mscb_pkg::SUM_BITS'(smp[a]);
                    o.binned = 1'b1;
                end
                fill_entry(o, r);
            end
            o.coverage = covered_regions[mscb_pkg::COVER_BITS-1:0];
            o.readings_taken = feeds_seen[mscb_pkg::FEED_BITS-1:0];
            o.bias_ready = feeds_seen > bias_count;
            pending = {pending, o};
        endfunction

        // compare one accepted result word with the oldest expectation
        task check_result(input mscb_pkg::out_word_t g);
            mscb_pkg::out_word_t e;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected word", 1, 0);
                return;
            end
            e = pending.pop_front();
            if (g.region != e.region) report_mismatch("region", g.region, e.region);
            if (g.binned != e.binned) report_mismatch("binned", g.binned, e.binned);
            if (g.region_samples != e.region_samples)
                report_mismatch("region_samples", g.region_samples, e.region_samples);
            if (g.sum_x != e.sum_x) report_mismatch("sum_x", g.sum_x, e.sum_x);
            if (g.sum_y != e.sum_y) report_mismatch("sum_y", g.sum_y, e.sum_y);
            if (g.sum_z != e.sum_z) report_mismatch("sum_z", g.sum_z, e.sum_z);
            if (g.coverage != e.coverage) report_mismatch("coverage", g.coverage, e.coverage);
            if (g.readings_taken != e.readings_taken)
                report_mismatch("readings_taken", g.readings_taken, e.readings_taken);
            if (g.bias_ready != e.bias_ready)
                report_mismatch("bias_ready", g.bias_ready, e.bias_ready);
        endtask
    endclass

    binner_scoreboard board;

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // sample accepted words at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_input(in_word);
        if (rst_n && out_valid && !out_stall)
        begin
            if (out_word.binned)
                binned_seen++;
            board.check_result(out_word);
        end
    end

    // receiver stall: random idling, a long hold-off on request
    initial
    begin
        int left;
        out_stall = 1'b0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && left == 0)
            begin
                left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (left > 0)
            begin
                left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= (!quiet && $urandom_range(99) < 11);
        end
    end

    // offer one word and hold it until accepted
    task automatic send_word(input mscb_pkg::in_word_t w);
        while (!quiet && $urandom_range(99) < 11)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_word  = w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic feed(input logic signed [15:0] x, input logic signed [15:0] y,
                        input logic signed [15:0] z);
        mscb_pkg::in_word_t w;
        w = '0;
        w.action = mscb_pkg::ACT_FEED;
        w.sample_x = x;
        w.sample_y = y;
        w.sample_z = z;
        w.region_pick = 7'($urandom);
        send_word(w);
        feeds_sent++;
    endtask

    task automatic read_region(input logic [6:0] r);
        mscb_pkg::in_word_t w;
        w = '0;
        w.sample_x = 16'($urandom);
        w.sample_y = 16'($urandom);
        w.sample_z = 16'($urandom);
        w.action = mscb_pkg::ACT_READ;
        w.region_pick = r;
        send_word(w);
        reads_sent++;
    endtask

    // wait for every expected word, then let the block settle
    task automatic drain();
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (70) @(negedge clk);
    endtask

    task automatic set_bias(input logic [mscb_pkg::BIAS_BITS-1:0] v);
        drain();
        bias_we   <= 1'b1;
        bias_data <= v;
        board.bias_count = v;
        @(negedge clk);
        bias_we <= 1'b0;
    endtask

    // random reading around a random field and offset
    task automatic random_feed(input int cx, input int cy, input int cz);
        int m;
        case ($urandom_range(9))
            0: feed(16'($urandom), 16'($urandom), 16'($urandom));
            1: feed(16'(cx), 16'(cy), 16'(cz));
            default:
            begin
                m = $urandom_range(9000, 200);
                feed(16'(cx + $signed($urandom_range(2 * m)) - m),
                     16'(cy + $signed($urandom_range(2 * m)) - m),
                     16'(cz + $signed($urandom_range(2 * m)) - m));
            end
        endcase
    endtask

    initial
    begin
        int cx;
        int cy;
        int cz;
        board = new();
        board.clear();
        errors = 0;
        cycles = 0;
        hold_req = 1'b0;
        quiet = 1'b0;
        rst_n = 1'b0;
        bias_we = 1'b0;
        bias_data = '0;
        in_valid = 1'b0;
        in_word = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reads of an empty store, short bias window, extremes
        read_region(7'd0);
        read_region(7'd99);
        read_region(7'd127);
        set_bias(10'd2);
        feed(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        feed(16'sh8000, 16'sh7FFF, 16'sh8000);
        feed(-16'sd1, -16'sd1, -16'sd1);
        feed(16'sd0, 16'sd0, 16'sd20000);
        feed(16'sd0, 16'sd0, -16'sd20000);
        feed(16'sd20000, 16'sd0, 16'sd0);
        feed(-16'sd20000, 16'sd0, 16'sd0);
        feed(16'sd0, 16'sd20000, 16'sd9000);
        feed(16'sd0, -16'sd20000, -16'sd9000);
        feed(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        feed(16'sh8000, 16'sh8000, 16'sh8000);
        read_region(7'd0);
        read_region(7'd99);
        read_region(7'd100);

        // zero bias window set mid-run
        drain();
        set_bias(10'd0);
        feed(16'sd0, 16'sd0, 16'sd0);
        feed(-16'sd1, -16'sd1, -16'sd1);
        read_region(7'd0);

        // random phases across bias settings, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_bias(10'd1023);
                1: set_bias(10'd1);
                2: set_bias(10'd100);
                default: set_bias(10'($urandom_range(1023)));
            endcase
            quiet = (ph == 3);
            cx = $signed($urandom_range(16000)) - 8000;
            cy = $signed($urandom_range(16000)) - 8000;
            cz = $signed($urandom_range(16000)) - 8000;
            for (int n = 0; n < 125; n++)
            begin
                if (ph == 4 && n == 20)
                    hold_req = 1'b1;
                if ($urandom_range(9) == 0)
                    read_region(7'($urandom_range(127)));
                else
                    random_feed(cx, cy, cz);
            end
        end
        quiet = 1'b0;
        for (int r = 0; r < 128; r++)
            read_region(7'(r));
        drain();

        $display("Sent %0d feeds and %0d reads; %0d feeds binned.",
                 feeds_sent, reads_sent, binned_seen);
        $display("Bias windows 0, 1, 2, 100, 1023 and random; long output hold-off.");
        if (errors == 0 && board.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
